// File: hw/rtl/sclf_pkg.sv
// shared types and constants of the sensor curve linearize filter
`default_nettype none

package sclf_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_MIN_VALID  = 3'd0;
   localparam logic [2:0] REG_MAX_VALID  = 3'd1;
   localparam logic [2:0] REG_TIMEOUT    = 3'd2;
   localparam logic [2:0] REG_FALLBACK   = 3'd3;
   localparam logic [2:0] REG_SHIFT      = 3'd4;
   localparam logic [2:0] REG_POINTS     = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_RANGE      = 2'd1;
   localparam logic [1:0] STATUS_DESCENDING = 2'd2;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_LOAD   = 1'b1;

   localparam logic [7:0] BAD_COUNT_MAX = 8'hFF;
   localparam logic [3:0] SHIFT_MASK    = 4'hF;
   localparam logic [3:0] SHIFT_LIMIT   = 4'd8;
   localparam logic [4:0] ACC_HALF      = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST,
      ST_LAST_D,
      ST_FIRST_D,
      ST_SRCH,
      ST_SRCH_D,
      ST_NEXT,
      ST_NEXT_D,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/sensor_curve_linearize_filter_unit.sv
// top level: curve table lookup with interpolation, fault timeout and smoothing
// path from the accepting edge to rsp_valid: an out-of-range sample goes to the last
// step, a clamped sample first reads the last and first points, an interpolated one
// also walks the table down (a ram read and compare per point) and runs the divider
// throughput: one word at a time; a load word is written on acceptance, a sample word
// waits in its last step while the previous result is not taken
// reset: synchronous, registers take their reset values; curve table not cleared
`default_nettype none

module sensor_curve_linearize_filter_unit import sclf_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_raw_reading,
   input  wire logic [3:0]  req_point_slot,
   input  wire logic [15:0] req_point_x,
   input  wire logic [15:0] req_point_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_sensor_value,
   output logic [1:0]       rsp_status,
   output logic             rsp_error_active,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = $clog2(MAX_POINTS);

   // configuration registers
   logic [15:0] min_valid_ff, max_valid_ff, fallback_ff;
   logic [7:0]  timeout_ff;
   logic [3:0]  shift_ff;
   logic [4:0]  points_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= 16'd0;
         max_valid_ff <= 16'hFFFF;
         timeout_ff   <= 8'd0;
         fallback_ff  <= 16'd0;
         shift_ff     <= 4'd4;
         points_ff    <= 5'd2;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MIN_VALID: min_valid_ff <= pwdata[15:0];
            REG_MAX_VALID: max_valid_ff <= pwdata[15:0];
            REG_TIMEOUT:   timeout_ff   <= pwdata[7:0];
            REG_FALLBACK:  fallback_ff  <= pwdata[15:0];
            REG_SHIFT:     shift_ff     <= pwdata[3:0];
            REG_POINTS:    points_ff    <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_idx)
         REG_MIN_VALID: prdata = {16'd0, min_valid_ff};
         REG_MAX_VALID: prdata = {16'd0, max_valid_ff};
         REG_TIMEOUT:   prdata = {24'd0, timeout_ff};
         REG_FALLBACK:  prdata = {16'd0, fallback_ff};
         REG_SHIFT:     prdata = {28'd0, shift_ff};
         REG_POINTS:    prdata = {27'd0, points_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // points in use, clamped to the table
   logic [4:0] n_pts;
   always_comb begin
      if (points_ff < 5'd2) begin
         n_pts = 5'd2;
      end else if (int'(points_ff) > MAX_POINTS) begin
         n_pts = 5'(MAX_POINTS);
      end else begin
         n_pts = points_ff;
      end
   end

   // sequencer and datapath state
   state_type   state_ff, state_in;
   logic [15:0] reading_ff;
   logic [15:0] xl_ff, yl_ff, x0_ff;
   logic [AW-1:0] idx_ff;
   logic [15:0] x1_ff, y1_ff, dx_ff;
   logic        up_ff;
   logic [31:0] prod_ff;
   logic [15:0] mapped_ff;
   logic        in_range_ff;
   logic [31:0] acc_ff;
   logic [15:0] held_ff;
   logic [7:0]  bad_ff;
   logic        err_ff;
   logic        cold_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_err_ff;

   logic        accept;
   logic        slot_free;
   logic        in_range;
   logic        slot_ok;
   logic [AW-1:0] rd_addr;
   logic [31:0] rd_data;
   logic [15:0] rd_x, rd_y;
   logic        div_start;
   logic        div_done;
   logic [15:0] div_q;

   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign in_range  = ~(req_raw_reading < min_valid_ff || req_raw_reading > max_valid_ff);
   assign slot_ok   = int'(req_point_slot) < MAX_POINTS;
   assign rd_x      = rd_data[31:16];
   assign rd_y      = rd_data[15:0];

   sclf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_curve (
      .clock   (clock),
      .wr_en   (accept & (req_kind == KIND_LOAD) & slot_ok),
      .wr_addr (AW'(req_point_slot)),
      .wr_data ({req_point_x, req_point_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sclf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_SAMPLE) begin
               state_in = in_range ? ST_LAST : ST_FIN;
            end
         end
         ST_LAST:    state_in = ST_LAST_D;
         ST_LAST_D:  state_in = ST_FIRST_D;
         ST_FIRST_D: begin
            if (reading_ff >= xl_ff || reading_ff <= rd_x) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH:    state_in = ST_SRCH_D;
         ST_SRCH_D:  state_in = (reading_ff > rd_x || idx_ff == '0) ? ST_NEXT : ST_SRCH;
         ST_NEXT:    state_in = ST_NEXT_D;
         ST_NEXT_D:  state_in = (rd_x <= x1_ff || rd_y == y1_ff) ? ST_FIN : ST_MUL;
         ST_MUL:     state_in = ST_DIV;
         ST_DIV:     state_in = div_done ? ST_FIN : ST_DIV;
         ST_FIN:     state_in = slot_free ? ST_IDLE : ST_FIN;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rd_addr   = '0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_LAST:  rd_addr = AW'(n_pts - 5'd1);
         ST_LAST_D: rd_addr = '0;
         ST_SRCH:  rd_addr = idx_ff;
         ST_NEXT:  rd_addr = AW'(idx_ff + 1'b1);
         ST_MUL:   div_start = 1'b1;
         default: ;
      endcase
   end

   // smoothing update of the accumulator
   logic [3:0]  k_eff;
   logic [31:0] acc_smooth;
   always_comb begin
      k_eff = shift_ff & SHIFT_MASK;
      if (k_eff > SHIFT_LIMIT) begin
         k_eff = SHIFT_LIMIT;
      end
      acc_smooth = acc_ff - (acc_ff >> k_eff)
                 + ({16'd0, mapped_ff} << (ACC_HALF - {1'b0, k_eff}));
   end

   logic [7:0] bad_inc;
   assign bad_inc = (bad_ff < BAD_COUNT_MAX) ? bad_ff + 8'd1 : bad_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         held_ff      <= '0;
         bad_ff       <= '0;
         err_ff       <= 1'b0;
         cold_ff      <= 1'b1;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_FIN && slot_free) | (rsp_valid_ff & ~rsp_ready);
         if (state_ff == ST_FIN && slot_free) begin
            if (!in_range_ff) begin
               bad_ff <= bad_inc;
               if (bad_inc > timeout_ff) begin
                  err_ff  <= 1'b1;
                  held_ff <= fallback_ff;
               end
            end else begin
               bad_ff <= '0;
               if (err_ff || cold_ff) begin
                  err_ff  <= 1'b0;
                  cold_ff <= 1'b0;
                  held_ff <= mapped_ff;
                  acc_ff  <= {mapped_ff, 16'd0};
               end else begin
                  acc_ff  <= acc_smooth;
                  held_ff <= acc_smooth[31:16];
               end
            end
         end
      end
   end

   // result word, formed from the values being committed
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && slot_free) begin
         if (!in_range_ff) begin
            rsp_status_ff <= STATUS_RANGE;
            rsp_value_ff  <= (bad_inc > timeout_ff) ? fallback_ff : held_ff;
            rsp_err_ff    <= (bad_inc > timeout_ff) | err_ff;
         end else begin
            rsp_status_ff <= (x0_ff > xl_ff) ? STATUS_DESCENDING : STATUS_OK;
            rsp_value_ff  <= (err_ff || cold_ff) ? mapped_ff : acc_smooth[31:16];
            rsp_err_ff    <= 1'b0;
         end
      end
   end

   // table walk and interpolation datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            reading_ff  <= req_raw_reading;
            in_range_ff <= in_range;
         end
         ST_LAST_D: begin
            xl_ff <= rd_x;
            yl_ff <= rd_y;
         end
         ST_FIRST_D: begin
            x0_ff  <= rd_x;
            idx_ff <= AW'(n_pts - 5'd2);
            if (reading_ff >= xl_ff) begin
               mapped_ff <= yl_ff;
            end else if (reading_ff <= rd_x) begin
               mapped_ff <= rd_y;
            end
         end
         ST_SRCH_D: begin
            if (reading_ff > rd_x || idx_ff == '0) begin
               x1_ff <= rd_x;
               y1_ff <= rd_y;
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
         ST_NEXT_D: begin
            mapped_ff <= y1_ff;
            dx_ff     <= rd_x - x1_ff;
            up_ff     <= rd_y > y1_ff;
         end
         ST_MUL: ;
         ST_DIV: begin
            if (div_done) begin
               mapped_ff <= up_ff ? y1_ff + div_q : y1_ff - div_q;
            end
         end
         default: ;
      endcase
   end

   // product for the divider, registered ahead of the start
   always_ff @(posedge clock) begin
      if (state_ff == ST_NEXT_D) begin
         prod_ff <= 32'(((rd_y > y1_ff) ? rd_y - y1_ff : y1_ff - rd_y))
                  * 32'(reading_ff - x1_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sensor_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_error_active = rsp_err_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sclf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sclf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/sclf_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module sclf_div import sclf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);

   logic [31:0] quo_ff;
   logic [15:0] rem_ff;
   logic [15:0] dsr_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [16:0] trial;
   logic        fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[31]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, the remainder stays below the divisor when the divisor is nonzero
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[30:0], fits};
         rem_ff <= fits ? 16'(trial - {1'b0, dsr_ff}) : trial[15:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[15:0];

endmodule

`default_nettype wire

// File: dv/sensor_curve_linearize_filter_unit_tb.sv
// testbench of the sensor curve linearize filter: directed and random words against a built-in predictor
`default_nettype none

module sensor_curve_linearize_filter_unit_tb import sclf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic        kind;
      logic [15:0] raw;
      logic [3:0]  slot;
      logic [15:0] px;
      logic [15:0] py;
   } sensor_word_type;

   typedef struct {
      logic [15:0] value;
      logic [1:0]  status;
      logic        err;
   } readout_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KIND_SAMPLE;
   logic [15:0] req_raw_reading = '0;
   logic [3:0]  req_point_slot = '0;
   logic [15:0] req_point_x = '0;
   logic [15:0] req_point_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sensor_value;
   logic [1:0]  rsp_status;
   logic        rsp_error_active;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sensor_curve_linearize_filter_unit dut (.*);

   always #4 clock = ~clock;

   // predictor copy of registers and state
   logic [15:0] cfg_min = 16'd0, cfg_max = 16'hFFFF, cfg_fallback = 16'd0;
   logic [7:0]  cfg_timeout = 8'd0;
   logic [3:0]  cfg_shift = 4'd4;
   logic [4:0]  cfg_points = 5'd2;
   logic [15:0] lut_x [TABLE_DEPTH];
   logic [15:0] lut_y [TABLE_DEPTH];
   logic [31:0] lp_accum = '0;
   logic [15:0] held = '0;
   logic [7:0]  bad_run = '0;
   logic        fault = 1'b0;
   logic        cold = 1'b1;

   sensor_word_type pending_words[$];
   readout_type     expected_readouts[$];
   int unsigned  words_sent = 0, words_taken = 0;
   int unsigned  gap_left = 0, stall_left = 0, cycles = 0, errors = 0;
   bit           sender_hold = 1'b0, calm = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // curve lookup with clamping and truncating interpolation
   function automatic logic [15:0] linearize(input logic [15:0] rd, input int n);
      int i;
      logic [31:0] x1, y1, x2, y2, dy, q;
      logic [63:0] prod;
      if (rd >= lut_x[n-1]) return lut_y[n-1];
      if (rd <= lut_x[0]) return lut_y[0];
      i = n - 2;
      while (i > 0 && !(rd > lut_x[i])) i--;
      x1 = lut_x[i]; y1 = lut_y[i]; x2 = lut_x[i+1]; y2 = lut_y[i+1];
      if (x2 <= x1 || y2 == y1) return y1[15:0];
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      prod = 64'(dy) * 64'(32'(rd) - x1);
      q = 32'(prod / 64'(x2 - x1));
      return (y2 > y1) ? 16'(y1 + q) : 16'(y1 - q);
   endfunction

   // one accepted word through the predictor
   task automatic predict_word(input sensor_word_type w);
      int n;
      int unsigned k;
      logic [15:0] mapped;
      logic [1:0] st;
      readout_type r;
      if (w.kind == KIND_LOAD) begin
         lut_x[w.slot] = w.px;
         lut_y[w.slot] = w.py;
         return;
      end
      st = STATUS_OK;
      if (w.raw < cfg_min || w.raw > cfg_max) begin
         if (bad_run != BAD_COUNT_MAX) bad_run++;
         if (bad_run > cfg_timeout) begin
            fault = 1'b1;
            held = cfg_fallback;
         end
         st = STATUS_RANGE;
      end else begin
         n = (cfg_points < 2) ? 2 : (cfg_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_points);
         bad_run = '0;
         mapped = linearize(w.raw, n);
         if (fault || cold) begin
            fault = 1'b0;
            cold = 1'b0;
            held = mapped;
            lp_accum = {mapped, 16'd0};
         end else begin
            k = cfg_shift & SHIFT_MASK;
            if (k > SHIFT_LIMIT) k = SHIFT_LIMIT;
            lp_accum = lp_accum - (lp_accum >> k);
            lp_accum = lp_accum + (32'(mapped) << (16 - k));
            held = lp_accum[31:16];
         end
         if (lut_x[0] > lut_x[n-1]) st = STATUS_DESCENDING;
      end
      r.value = held; r.status = st; r.err = fault;
      expected_readouts.push_back(r);
   endtask

   // monitor: check results, then take accepted words
   always @(posedge clock) begin
      readout_type e;
      sensor_word_type w;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readouts.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               e = expected_readouts.pop_front();
               if (rsp_sensor_value !== e.value)
                  report_mismatch($sformatf("sensor_value %h want %h", rsp_sensor_value, e.value));
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status %0d want %0d", rsp_status, e.status));
               if (rsp_error_active !== e.err)
                  report_mismatch($sformatf("error_active %b want %b", rsp_error_active, e.err));
            end
         end
         if (req_valid && req_ready) begin
            w.kind = req_kind; w.raw = req_raw_reading; w.slot = req_point_slot;
            w.px = req_point_x; w.py = req_point_y;
            predict_word(w);
            words_taken++;
         end
      end
   end

   // driver: one word at a time from the pending queue
   always @(negedge clock) begin
      sensor_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && words_taken != words_sent) begin
         // hold until taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (!sender_hold && pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_kind <= w.kind; req_raw_reading <= w.raw; req_point_slot <= w.slot;
         req_point_x <= w.px; req_point_y <= w.py;
         req_valid <= 1'b1;
         words_sent++;
         if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 13);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MIN_VALID: cfg_min = val[15:0];
         REG_MAX_VALID: cfg_max = val[15:0];
         REG_TIMEOUT:   cfg_timeout = val[7:0];
         REG_FALLBACK:  cfg_fallback = val[15:0];
         REG_SHIFT:     cfg_shift = val[3:0];
         REG_POINTS:    cfg_points = val[4:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || words_taken != words_sent || req_valid)
         @(posedge clock);
      while (expected_readouts.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_sample(input logic [15:0] rd);
      sensor_word_type w;
      w.kind = KIND_SAMPLE; w.raw = rd;
      w.slot = 4'($urandom()); w.px = 16'($urandom()); w.py = 16'($urandom());
      pending_words.push_back(w);
   endtask

   task automatic push_load(input logic [3:0] s, input logic [15:0] x, input logic [15:0] y);
      sensor_word_type w;
      w.kind = KIND_LOAD; w.slot = s; w.px = x; w.py = y; w.raw = 16'($urandom());
      pending_words.push_back(w);
   endtask

   // ascending table, now and then with repeated x or y
   task automatic load_sorted_table();
      logic [15:0] x, y;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i == 0 || $urandom_range(0, 7) != 0) x = 16'(i * 4096 + $urandom_range(0, 4095));
         if (i == 0 || $urandom_range(0, 5) != 0) y = 16'($urandom());
         push_load(4'(i), x, y);
      end
   endtask

   task automatic random_sample();
      if (cfg_min <= cfg_max && $urandom_range(0, 4) != 0)
         push_sample(16'($urandom_range(cfg_min, cfg_max)));
      else
         push_sample(16'($urandom()));
   endtask

   initial begin
      logic [15:0] lo, hi;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full table load, then extremes and special cases
      csr_write(REG_POINTS, 32'd16);
      for (int i = 0; i < TABLE_DEPTH; i++)
         push_load(4'(i), 16'(i * 4000 + 2000), (i == 3) ? 16'd9000 : 16'(i * 3000));
      push_load(4'd4, 16'd18000, 16'd9000);    // equal y on a segment
      push_load(4'd6, 16'd22000, 16'd60000);   // equal x with slot 5, y jumps up
      push_load(4'd7, 16'd22000, 16'd1000);    // equal x
      push_sample(16'd0);
      push_sample(16'hFFFF);
      push_sample(16'd6000);
      push_sample(16'd7001);
      push_sample(16'd16500);
      push_sample(16'd21000);
      push_sample(16'd23000);
      drain();

      // random phases over register settings, extremes first
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin csr_write(REG_MIN_VALID, 0); csr_write(REG_MAX_VALID, 32'hFFFF);
               csr_write(REG_TIMEOUT, 0); csr_write(REG_FALLBACK, 32'hFFFF);
               csr_write(REG_SHIFT, 0); csr_write(REG_POINTS, 16); end
            1: begin csr_write(REG_MIN_VALID, 1000); csr_write(REG_MAX_VALID, 60000);
               csr_write(REG_TIMEOUT, 3); csr_write(REG_FALLBACK, 1234);
               csr_write(REG_SHIFT, 15); csr_write(REG_POINTS, 0); end
            2: begin csr_write(REG_MIN_VALID, 32'hFFFF); csr_write(REG_MAX_VALID, 32'hFFFF);
               csr_write(REG_TIMEOUT, 255); csr_write(REG_FALLBACK, 32'h5A5A);
               csr_write(REG_SHIFT, 8); csr_write(REG_POINTS, 31); end
            3: begin csr_write(REG_MIN_VALID, 0); csr_write(REG_MAX_VALID, 0);
               csr_write(REG_TIMEOUT, 1); csr_write(REG_FALLBACK, 32'hA5A5);
               csr_write(REG_SHIFT, 9); csr_write(REG_POINTS, 1); end
            default: begin
               lo = 16'($urandom_range(0, 30000)); hi = 16'($urandom_range(lo, 65535));
               csr_write(REG_MIN_VALID, lo); csr_write(REG_MAX_VALID, hi);
               csr_write(REG_TIMEOUT, $urandom_range(0, 6));
               csr_write(REG_FALLBACK, $urandom_range(0, 65535));
               csr_write(REG_SHIFT, $urandom_range(0, 15));
               csr_write(REG_POINTS, $urandom_range(0, 31));
            end
         endcase
         if ($urandom_range(0, 1) == 0) load_sorted_table();
         if (ph == 7) calm = 1'b1;
         for (int j = 0; j < 45; j++) begin
            if ($urandom_range(0, 9) == 0)
               push_load(4'($urandom()), 16'($urandom()), 16'($urandom()));
            else if ($urandom_range(0, 11) == 0)
               push_sample(16'($urandom()));
            else
               random_sample();
         end
         if (ph == 4) begin
            // sender pauses mid-stream until every result is out
            while (pending_words.size() > 40) @(posedge clock);
            sender_hold = 1'b1;
            while (req_valid || expected_readouts.size() > 0) @(posedge clock);
            sender_hold = 1'b0;
         end
         drain();
         if (ph == 5) begin
            // inverted window, long bad run into counter saturation
            csr_write(REG_MIN_VALID, 32'hFFFF); csr_write(REG_MAX_VALID, 0);
            csr_write(REG_TIMEOUT, 254);
            for (int j = 0; j < 262; j++) push_sample(16'($urandom()));
            drain();
            csr_write(REG_MIN_VALID, 0); csr_write(REG_MAX_VALID, 32'hFFFF);
            for (int j = 0; j < 5; j++) push_sample(16'($urandom()));
            drain();
         end
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/sclf_pkg.sv
hw/rtl/sclf_ram.sv
hw/rtl/sclf_div.sv
hw/rtl/sensor_curve_linearize_filter_unit.sv
dv/sensor_curve_linearize_filter_unit_tb.sv
